[hdl/clpe_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, register codes, reset values and types of the curvature low-pass estimator.
package clpe_pkg;

  localparam int CURV_BITS  = 32;
  localparam int OUT_W      = 32;
  localparam int YAW_W      = 20;
  localparam int SPD_W      = 18;
  localparam int COEF_W     = 18;
  localparam int MINSPD_W   = 16;
  localparam int LIM_W      = 31;
  localparam int FRAC_SHIFT = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int DIV_N_W     = YAW_W + FRAC_SHIFT;
  localparam int DIV_STEPS   = DIV_N_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int MAC_TERMS   = 3;
  localparam int PROD_W      = COEF_W + CURV_BITS;
  localparam int ACC_W       = PROD_W + 2;

  localparam logic [1:0] FILL_FULL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_OLDER = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_NEWER = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_INPUT = 3'd5;

  localparam logic [MINSPD_W-1:0]      RST_MIN_SPEED  = 16'd256;
  localparam logic [LIM_W-1:0]         RST_LOW_LIMIT  = 31'd419;
  localparam logic [LIM_W-1:0]         RST_HIGH_LIMIT = 31'd1048576;
  localparam logic signed [COEF_W-1:0] RST_COEF_OLDER = -18'sd44959;
  localparam logic signed [COEF_W-1:0] RST_COEF_NEWER = 18'sd108561;
  localparam logic signed [COEF_W-1:0] RST_COEF_INPUT = 18'sd1933;

  localparam logic signed [CURV_BITS-1:0] CURV_MAX = {1'b0, {(CURV_BITS-1){1'b1}}};
  localparam logic signed [CURV_BITS-1:0] CURV_MIN = {1'b1, {(CURV_BITS-1){1'b0}}};

  typedef struct packed {
    logic [LIM_W-1:0]         low_lim;
    logic [LIM_W-1:0]         high_lim;
    logic signed [COEF_W-1:0] coef_older;
    logic signed [COEF_W-1:0] coef_newer;
    logic signed [COEF_W-1:0] coef_input;
  } clpe_cfg_t;

  typedef struct packed {
    logic             straight;
    logic             neg;
    logic             yaw_zero;
    logic [YAW_W-1:0] yaw_mag;
    logic [SPD_W-1:0] spd_mag;
  } clpe_item_t;

endpackage

[hdl/curvature_lowpass_estimator.sv]
`timescale 1ns / 1ps
// Top level of the curvature low-pass estimator: configuration registers and front/queue/back.
//
//   channel  signals                                   direction
//   cfg      cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i   in (register write)
//   in       in_valid_i in_ready_o yaw_rate_i speed_i         in (one sample per beat)
//   out      out_valid_o out_ready_i curvature_o              out (one result per beat)
//
// A curve beat passes front register, queue, divider and handoff, raw saturation,
// multiply-accumulate, rounding, thresholds and output register. The serial divider
// limits the rate: the back end takes no new beat until the last result is registered.
// A straight-road beat skips the divider and filter and leaves with a zero result.
// Reset loads the register defaults and clears filter history and fill count.
// The front register and a two-entry queue take new beats while a result waits.
module curvature_lowpass_estimator import clpe_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [YAW_W-1:0]  yaw_rate_i,
  input  logic signed [SPD_W-1:0]  speed_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [OUT_W-1:0]  curvature_o
);

  logic [MINSPD_W-1:0] min_speed_q;
  clpe_cfg_t           cfg_q;
  logic                fr_valid, fr_ready;
  clpe_item_t          fr_item;
  logic                q_valid, q_ready;
  clpe_item_t          q_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q      <= RST_MIN_SPEED;
      cfg_q.low_lim    <= RST_LOW_LIMIT;
      cfg_q.high_lim   <= RST_HIGH_LIMIT;
      cfg_q.coef_older <= RST_COEF_OLDER;
      cfg_q.coef_newer <= RST_COEF_NEWER;
      cfg_q.coef_input <= RST_COEF_INPUT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MIN_SPEED:  min_speed_q      <= cfg_data_i[MINSPD_W-1:0];
        REG_LOW_LIMIT:  cfg_q.low_lim    <= cfg_data_i[LIM_W-1:0];
        REG_HIGH_LIMIT: cfg_q.high_lim   <= cfg_data_i[LIM_W-1:0];
        REG_COEF_OLDER: cfg_q.coef_older <= cfg_data_i[COEF_W-1:0];
        REG_COEF_NEWER: cfg_q.coef_newer <= cfg_data_i[COEF_W-1:0];
        REG_COEF_INPUT: cfg_q.coef_input <= cfg_data_i[COEF_W-1:0];
        default: begin
        end
      endcase
    end
  end

  clpe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .yaw_rate_i   (yaw_rate_i),
    .speed_i      (speed_i),
    .min_speed_i  (min_speed_q),
    .item_valid_o (fr_valid),
    .item_ready_i (fr_ready),
    .item_o       (fr_item)
  );

  clpe_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_item_i  (fr_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  clpe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .curvature_o (curvature_o)
  );

endmodule

[hdl/clpe_front.sv]
`timescale 1ns / 1ps
// Front end: accepts samples, splits them into magnitude and sign, flags straight-road beats.
module clpe_front import clpe_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [YAW_W-1:0]    yaw_rate_i,
  input  logic signed [SPD_W-1:0]    speed_i,
  input  logic [MINSPD_W-1:0]        min_speed_i,
  output logic                       item_valid_o,
  input  logic                       item_ready_i,
  output clpe_item_t                 item_o
);

  logic       fr_valid_q;
  clpe_item_t item_d, item_q;
  logic       yaw_neg, spd_neg;

  always_comb begin
    yaw_neg          = yaw_rate_i[YAW_W-1];
    spd_neg          = speed_i[SPD_W-1];
    item_d.yaw_mag   = yaw_neg ? YAW_W'(-yaw_rate_i) : YAW_W'(yaw_rate_i);
    item_d.spd_mag   = spd_neg ? SPD_W'(-speed_i) : SPD_W'(speed_i);
    item_d.straight  = item_d.spd_mag < SPD_W'(min_speed_i);
    item_d.neg       = yaw_neg ^ spd_neg;
    item_d.yaw_zero  = (yaw_rate_i == '0);
  end

  assign in_ready_o   = !fr_valid_q || item_ready_i;
  assign item_valid_o = fr_valid_q;
  assign item_o       = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
      item_q     <= '0;
    end else if (in_valid_i && in_ready_o) begin
      fr_valid_q <= 1'b1;
      item_q     <= item_d;
    end else if (item_ready_i) begin
      fr_valid_q <= 1'b0;
    end
  end

endmodule

[hdl/clpe_fifo.sv]
`timescale 1ns / 1ps
// Short queue of classified beats between the front end and the filter back end.
module clpe_fifo import clpe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  clpe_item_t push_item_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output clpe_item_t pop_item_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  clpe_item_t        mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || count_q == CNT_W'(QUEUE_DEPTH)) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with count");

endmodule

[hdl/clpe_div.sv]
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module clpe_div import clpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] dividend_i,
  input  logic [SPD_W-1:0]   divisor_i,
  output logic               busy_o,
  output logic               done_o,
  output logic [DIV_N_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [DIV_N_W-1:0] quo_q;
  logic [SPD_W-1:0]   rem_q, dvs_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               busy_q, done_q;
  logic [SPD_W:0]     rem_sh;
  logic [SPD_W+1:0]   diff;
  logic               ge;

  always_comb begin
    rem_sh = {rem_q, quo_q[DIV_N_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    ge     = !diff[SPD_W+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quo_q  <= dividend_i;
        rem_q  <= '0;
        dvs_q  <= divisor_i;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        quo_q <= {quo_q[DIV_N_W-2:0], ge};
        rem_q <= ge ? diff[SPD_W-1:0] : rem_sh[SPD_W-1:0];
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

[hdl/clpe_back.sv]
`timescale 1ns / 1ps
// Back end: raw curvature division, second-order low-pass filter, thresholds and output register.
module clpe_back import clpe_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  clpe_cfg_t             cfg_i,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  clpe_item_t            q_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [OUT_W-1:0] curvature_o
);

  localparam int SAT_W = ((DIV_N_W > CURV_BITS) ? DIV_N_W : CURV_BITS) + 1;
  localparam int CMP_W = (CURV_BITS > LIM_W) ? CURV_BITS : LIM_W;
  localparam logic signed [SAT_W-1:0] SMAX = SAT_W'(CURV_MAX);
  localparam logic signed [SAT_W-1:0] SMIN = SAT_W'(CURV_MIN);
  localparam logic signed [ACC_W-1:0] AMAX = ACC_W'(CURV_MAX);
  localparam logic signed [ACC_W-1:0] AMIN = ACC_W'(CURV_MIN);
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) <<< (FRAC_SHIFT - 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIV   = 7'b0000010,
    S_RAW   = 7'b0000100,
    S_MAC   = 7'b0001000,
    S_ROUND = 7'b0010000,
    S_THR   = 7'b0100000,
    S_OUT   = 7'b1000000
  } clpe_state_e;

  clpe_state_e                st_q;
  clpe_item_t                 item_q;
  logic [1:0]                 fill_q;
  logic [1:0]                 cnt_q;
  logic signed [CURV_BITS-1:0] hist0_q, hist1_q, raw_q, y_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [OUT_W-1:0]    res_q, curv_q;
  logic                       out_valid_q;

  logic                       div_start, div_busy, div_done;
  logic [DIV_N_W-1:0]         div_quo;

  logic signed [SAT_W-1:0]    q_ext, q_sgn;
  logic signed [CURV_BITS-1:0] raw_d, y_d, mul_b;
  logic signed [COEF_W-1:0]   mul_a;
  logic signed [ACC_W-1:0]    acc_sh;
  logic [CURV_BITS-1:0]       ay;
  logic signed [OUT_W-1:0]    high_s, res_d;

  assign div_start = (st_q == S_IDLE) && q_valid_i && !q_item_i.straight;
  assign q_ready_o = (st_q == S_IDLE);

  clpe_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({q_item_i.yaw_mag, {FRAC_SHIFT{1'b0}}}),
    .divisor_i  (q_item_i.spd_mag),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    q_ext = signed'(SAT_W'(div_quo));
    q_sgn = item_q.neg ? -q_ext : q_ext;
    if (item_q.yaw_zero) begin
      raw_d = '0;
    end else if (q_sgn > SMAX) begin
      raw_d = CURV_MAX;
    end else if (q_sgn < SMIN) begin
      raw_d = CURV_MIN;
    end else begin
      raw_d = q_sgn[CURV_BITS-1:0];
    end
  end

  always_comb begin
    case (cnt_q)
      2'd0: begin
        mul_a = cfg_i.coef_older;
        mul_b = hist1_q;
      end
      2'd1: begin
        mul_a = cfg_i.coef_newer;
        mul_b = hist0_q;
      end
      2'd2: begin
        mul_a = cfg_i.coef_input;
        mul_b = raw_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    acc_sh = acc_q >>> FRAC_SHIFT;
    if (acc_sh > AMAX) begin
      y_d = CURV_MAX;
    end else if (acc_sh < AMIN) begin
      y_d = CURV_MIN;
    end else begin
      y_d = acc_sh[CURV_BITS-1:0];
    end
  end

  always_comb begin
    ay     = y_q[CURV_BITS-1] ? CURV_BITS'(-y_q) : CURV_BITS'(y_q);
    high_s = OUT_W'(signed'({1'b0, cfg_i.high_lim}));
    if (CMP_W'(ay) < CMP_W'(cfg_i.low_lim)) begin
      res_d = '0;
    end else if (CMP_W'(ay) > CMP_W'(cfg_i.high_lim)) begin
      res_d = y_q[CURV_BITS-1] ? -high_s : high_s;
    end else begin
      res_d = OUT_W'(y_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      item_q      <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      hist0_q     <= '0;
      hist1_q     <= '0;
      raw_q       <= '0;
      y_q         <= '0;
      prod_q      <= '0;
      acc_q       <= '0;
      res_q       <= '0;
      curv_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_ready_i && st_q != S_OUT) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        S_IDLE: begin
          if (q_valid_i) begin
            item_q <= q_item_i;
            if (q_item_i.straight) begin
              res_q <= '0;
              st_q  <= S_OUT;
            end else begin
              st_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            st_q <= S_RAW;
          end
        end
        S_RAW: begin
          raw_q <= raw_d;
          if (fill_q < FILL_FULL) begin
            hist1_q <= hist0_q;
            hist0_q <= raw_d;
            fill_q  <= fill_q + 1'b1;
            res_q   <= '0;
            st_q    <= S_OUT;
          end else begin
            acc_q <= ROUND_BIAS;
            cnt_q <= '0;
            st_q  <= S_MAC;
          end
        end
        S_MAC: begin
          prod_q <= mul_a * mul_b;
          if (cnt_q != 2'd0) begin
            acc_q <= acc_q + ACC_W'(prod_q);
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 2'(MAC_TERMS)) begin
            st_q <= S_ROUND;
          end
        end
        S_ROUND: begin
          y_q     <= y_d;
          hist1_q <= hist0_q;
          hist0_q <= y_d;
          st_q    <= S_THR;
        end
        S_THR: begin
          res_q <= res_d;
          st_q  <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            curv_q      <= res_q;
            st_q        <= S_IDLE;
          end
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign curvature_o = curv_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_FULL)
    else $error("history fill count overrun");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (st_q == S_DIV))
    else $error("divider running outside divide state");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_IDLE && q_valid_i && q_item_i.straight) |=>
      ($stable(hist0_q) && $stable(hist1_q) && $stable(fill_q)))
    else $error("straight-road beat disturbed filter history");

endmodule

[dv/curvature_lowpass_estimator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the curvature low-pass estimator: directed and random samples.
module curvature_lowpass_estimator_tb;
  import clpe_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = 3'd7;
  localparam int IDLE_PCT     = 19;
  localparam int CALM_FROM    = 400;
  localparam int CALM_TO      = 520;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_LEN     = 500;
  localparam int DRAIN_CYCLES = 64;
  localparam int STALL_LIMIT  = 5000;
  localparam int YAW_HI       = 524287;
  localparam int YAW_LO       = -524288;
  localparam int SPD_HI       = 131071;
  localparam int SPD_LO       = -131072;

  typedef struct packed {
    logic [YAW_W-1:0] yaw;
    logic [SPD_W-1:0] spd;
  } sample_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                    clk_i;
  logic                    rst_ni    = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data  = '0;
  logic                    in_valid  = 1'b0;
  logic signed [YAW_W-1:0] yaw_rate  = '0;
  logic signed [SPD_W-1:0] speed     = '0;
  logic                    out_ready = 1'b0;
  logic                    cfg_ready;
  logic                    in_ready;
  logic                    out_valid;
  logic signed [OUT_W-1:0] curvature;

  sample_t    sample_q[$];
  reg_write_t reg_write_q[$];
  logic signed [OUT_W-1:0] curv_expect_q[$];
  sample_t    next_sample;
  reg_write_t next_write;
  logic signed [OUT_W-1:0] predicted;
  logic signed [OUT_W-1:0] want;

  logic [MINSPD_W-1:0]      min_spd;
  logic [LIM_W-1:0]         low_lim;
  logic [LIM_W-1:0]         high_lim;
  logic signed [COEF_W-1:0] c_old;
  logic signed [COEF_W-1:0] c_new;
  logic signed [COEF_W-1:0] c_in;
  longint                   hist_new;
  longint                   hist_old;
  logic [1:0]               fill_cnt;

  int items_queued = 0;
  int items_taken  = 0;
  int regs_queued  = 0;
  int regs_taken   = 0;
  int results_seen = 0;
  int nonzero_seen = 0;
  int err_cnt      = 0;
  int hold_left    = 0;
  int settings_cnt = 1;
  int stall_cnt    = 0;

  curvature_lowpass_estimator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .yaw_rate_i  (yaw_rate),
    .speed_i     (speed),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .curvature_o (curvature)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic bit take_break(input int n);
    return (n < CALM_FROM || n >= CALM_TO) && ($urandom_range(99) < IDLE_PCT);
  endfunction

  function automatic longint clip_curv(input longint v);
    if (v > longint'(CURV_MAX)) return longint'(CURV_MAX);
    if (v < longint'(CURV_MIN)) return longint'(CURV_MIN);
    return v;
  endfunction

  function automatic int clip_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  task automatic track_curvature(input logic signed [YAW_W-1:0] yaw,
                                 input logic signed [SPD_W-1:0] spd,
                                 output logic signed [OUT_W-1:0] curv);
    longint y, s, mag, floor_spd, raw, acc, filt, mag_f, lim_lo, lim_hi;
    y         = longint'(yaw);
    s         = longint'(spd);
    mag       = (s < 0) ? -s : s;
    floor_spd = longint'(min_spd);
    lim_lo    = longint'(low_lim);
    lim_hi    = longint'(high_lim);
    curv      = '0;
    if (mag >= floor_spd) begin
      if (s == 0) begin
        raw = (y > 0) ? longint'(CURV_MAX) : ((y < 0) ? longint'(CURV_MIN) : 0);
      end else begin
        raw = clip_curv((y * (longint'(1) <<< FRAC_SHIFT)) / s);
      end
      if (fill_cnt != FILL_FULL) begin
        hist_old = hist_new;
        hist_new = raw;
        fill_cnt = fill_cnt + 2'd1;
      end else begin
        acc = longint'(c_old) * hist_old + longint'(c_new) * hist_new + longint'(c_in) * raw;
        filt = clip_curv((acc + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT);
        hist_old = hist_new;
        hist_new = filt;
        mag_f = (filt < 0) ? -filt : filt;
        if (mag_f < lim_lo) begin
          curv = '0;
        end else if (mag_f > lim_hi) begin
          curv = (filt < 0) ? OUT_W'(-lim_hi) : OUT_W'(lim_hi);
        end else begin
          curv = OUT_W'(filt);
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_valid <= 1'b0;
      min_spd   = RST_MIN_SPEED;
      low_lim   = RST_LOW_LIMIT;
      high_lim  = RST_HIGH_LIMIT;
      c_old     = RST_COEF_OLDER;
      c_new     = RST_COEF_NEWER;
      c_in      = RST_COEF_INPUT;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MIN_SPEED:  min_spd  = cfg_data[MINSPD_W-1:0];
          REG_LOW_LIMIT:  low_lim  = cfg_data[LIM_W-1:0];
          REG_HIGH_LIMIT: high_lim = cfg_data[LIM_W-1:0];
          REG_COEF_OLDER: c_old    = cfg_data[COEF_W-1:0];
          REG_COEF_NEWER: c_new    = cfg_data[COEF_W-1:0];
          REG_COEF_INPUT: c_in     = cfg_data[COEF_W-1:0];
          default: ;
        endcase
        regs_taken++;
      end
      if (!cfg_valid || cfg_ready) begin
        if (reg_write_q.size() > 0) begin
          next_write = reg_write_q.pop_front();
          cfg_valid <= 1'b1;
          cfg_index <= next_write.idx;
          cfg_data  <= next_write.data;
        end else begin
          cfg_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      hist_new = 0;
      hist_old = 0;
      fill_cnt = '0;
    end else begin
      if (in_valid && in_ready) begin
        track_curvature(yaw_rate, speed, predicted);
        curv_expect_q.push_back(predicted);
        items_taken++;
      end
      if (!in_valid || in_ready) begin
        if (sample_q.size() > 0 && !take_break(items_taken)) begin
          next_sample = sample_q.pop_front();
          in_valid <= 1'b1;
          yaw_rate <= next_sample.yaw;
          speed    <= next_sample.spd;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (curv_expect_q.size() == 0) begin
          $error("curvature: result %0d with none expected", curvature);
          err_cnt++;
        end else begin
          want = curv_expect_q.pop_front();
          if (curvature !== want) begin
            $error("curvature: expected %0d, actual %0d", want, curvature);
            err_cnt++;
          end
        end
        results_seen++;
        if (curvature != '0) nonzero_seen++;
        if (results_seen == HOLD_AT) hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !take_break(results_seen);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        stall_cnt = 0;
      end else begin
        stall_cnt++;
      end
      if (stall_cnt >= STALL_LIMIT) begin
        $error("no beat on any channel for %0d cycles", STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic queue_sample(input int yaw, input int spd);
    sample_t smp;
    smp.yaw = YAW_W'(yaw);
    smp.spd = SPD_W'(spd);
    sample_q.push_back(smp);
    items_queued++;
  endtask

  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    reg_write_t wr;
    wr.idx  = idx;
    wr.data = data;
    reg_write_q.push_back(wr);
    regs_queued++;
  endtask

  task automatic await_results();
    while (items_taken != items_queued || curv_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [31:0] ms, input logic [31:0] lo,
                              input logic [31:0] hi, input logic [31:0] co,
                              input logic [31:0] cn, input logic [31:0] ci);
    queue_reg(REG_MIN_SPEED, ms);
    queue_reg(REG_LOW_LIMIT, lo);
    queue_reg(REG_HIGH_LIMIT, hi);
    queue_reg(REG_COEF_OLDER, co);
    queue_reg(REG_COEF_NEWER, cn);
    queue_reg(REG_COEF_INPUT, ci);
    while (regs_taken != regs_queued) @(posedge clk_i);
    settings_cnt++;
  endtask

  // Mostly runs of steady driving with jitter, some noise and some near-standstill samples.
  task automatic queue_random(input int n);
    int left, run, mode, base_yaw, base_spd, y, s;
    left = n;
    while (left > 0) begin
      run  = $urandom_range(4, 24);
      mode = $urandom_range(99);
      base_spd = (mode < 70) ? $urandom_range(256, 12000) : $urandom_range(0, SPD_HI);
      if ($urandom_range(4) == 0) base_spd = -base_spd;
      base_yaw = int'($urandom_range(0, YAW_HI) >> $urandom_range(0, 12));
      if ($urandom_range(1) == 1) base_yaw = -base_yaw - 1;
      for (int k = 0; k < run && left > 0; k++) begin
        if (mode < 15) begin
          queue_sample($urandom, $urandom);
        end else if ($urandom_range(9) == 0) begin
          s = int'($urandom_range(0, 300));
          queue_sample(base_yaw, ($urandom_range(1) == 1) ? -s : s);
        end else begin
          y = clip_int(base_yaw + int'($urandom_range(0, 64)) - 32, YAW_LO, YAW_HI);
          s = clip_int(base_spd + int'($urandom_range(0, 32)) - 16, SPD_LO, SPD_HI);
          queue_sample(y, s);
        end
        left--;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: filling the history, speed threshold edges, field extremes
    queue_sample(0, 256);
    queue_sample(YAW_HI, 256);
    queue_sample(YAW_HI, 256);
    queue_sample(YAW_LO, 256);
    queue_sample(1000, 255);
    queue_sample(1000, -255);
    queue_sample(1000, -256);
    queue_sample(YAW_LO, SPD_LO);
    queue_sample(YAW_HI, SPD_HI);
    queue_sample(1, SPD_HI);
    await_results();

    // zero threshold and extreme weights: standstill and divider saturation
    program_regs(32'd0, 32'd0, 32'h7FFF_FFFF, -131072, 131071, 131071);
    queue_sample(100, 0);
    queue_sample(-100, 0);
    queue_sample(0, 0);
    queue_sample(YAW_HI, 1);
    queue_sample(YAW_LO, 1);
    queue_sample(YAW_HI, -1);
    await_results();

    // zero band wider than the clamp; spare indexes carry no register
    queue_reg(REG_SPARE, 32'hFFFF_FFFF);
    queue_reg(REG_SPARE_TOP, 32'h0000_0000);
    program_regs(32'hFFFF_FFFF, 32'd5000, 32'd1000, 32'(RST_COEF_OLDER),
                 32'(RST_COEF_NEWER), 32'(RST_COEF_INPUT));
    queue_sample(300000, 65535);
    queue_sample(-300000, -65535);
    queue_sample(300000, 65534);
    queue_sample(YAW_LO, SPD_LO);
    queue_sample(YAW_HI, SPD_HI);
    queue_sample(20000, 65535);
    await_results();

    program_regs(32'(RST_MIN_SPEED), 32'(RST_LOW_LIMIT), 32'(RST_HIGH_LIMIT),
                 32'(RST_COEF_OLDER), 32'(RST_COEF_NEWER), 32'(RST_COEF_INPUT));
    queue_random(300);
    await_results();

    program_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    queue_random(100);
    await_results();

    program_regs($urandom_range(0, 2000), $urandom_range(0, 5000),
                 $urandom_range(5000, 4000000), 32'(RST_COEF_OLDER), 32'(RST_COEF_NEWER),
                 32'(RST_COEF_INPUT));
    queue_random(150);
    await_results();

    program_regs(32'd1, 32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 131071);
    queue_random(100);
    await_results();

    queue_reg(REG_SPARE, $urandom);
    program_regs($urandom_range(0, 1000), $urandom, $urandom, $urandom, $urandom, $urandom);
    queue_random(60);
    await_results();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Ran %0d samples over %0d register settings (%0d register writes).",
             items_taken, settings_cnt, regs_taken);
    $display("Checked %0d curvature results, %0d of them nonzero.", results_seen, nonzero_seen);
    if (err_cnt == 0 && curv_expect_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
